/* rtl/core/smpq_pkg.sv */
// smpq_pkg: shared types and codes for the sorted minimum priority queue
// no dependencies; imported by the interfaces and every rtl/core module
`default_nettype none

package smpq_pkg;

    // input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // fixed payload widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FILL_W = 5;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller to datapath command
    typedef struct packed {
        logic go;
        logic remove;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/core/smpq_if.sv */
// smpq_in_if / smpq_out_if: valid-ready channels for input and result beats
// depends on smpq_pkg
`default_nettype none

interface smpq_in_if;
    import smpq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface smpq_out_if;
    import smpq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0]        status;
    logic [FILL_W-1:0]          fill_level;

    modport source (output valid, output result_value, output status,
                    output fill_level, input ready);
    modport sink   (input valid, input result_value, input status,
                    input fill_level, output ready);
endinterface

`default_nettype wire

/* rtl/core/smpq_ctrl.sv */
// smpq_ctrl: handshake controller, owns the result register valid state
// depends on smpq_pkg
`default_nettype none

module smpq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output smpq_pkg::t_cmd      o_cmd
);
    import smpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // a new beat is taken when the result register is free or draining
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);

    assign o_cmd.go     = accept;
    assign o_cmd.remove = (i_in_action == ACT_REMOVE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready && !accept) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/smpq_dp.sv */
// smpq_dp: row of compare-and-shift cells, entry count and result register
// depends on smpq_pkg
`default_nettype none

module smpq_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire smpq_pkg::t_cmd                     i_cmd,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0] i_value,
    output logic signed [smpq_pkg::VALUE_W-1:0]     o_result_value,
    output logic [smpq_pkg::STATUS_W-1:0]           o_status,
    output logic [smpq_pkg::FILL_W-1:0]             o_fill_level
);
    import smpq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0]  r_cells [DEPTH];
    logic signed [VALUE_W-1:0]  n_ins   [DEPTH];
    logic signed [VALUE_W-1:0]  n_rem   [DEPTH];
    logic [DEPTH-1:0]           lt;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       empty;
    logic                       full;
    logic [31:0]                count_ext;

    logic signed [VALUE_W-1:0]  r_result_value;
    logic [STATUS_W-1:0]        r_status;
    logic [FILL_W-1:0]          r_fill_level;

    assign empty = (r_count == '0);
    assign full  = (r_count == CW'(DEPTH));

    // per-cell compare and shift sources
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign lt[g] = (CW'(g) < r_count) && (r_cells[g] < i_value);
        if (g == 0) begin : g_head
            assign n_ins[g] = lt[g] ? r_cells[g] : i_value;
        end else begin : g_body
            assign n_ins[g] = lt[g] ? r_cells[g] : (lt[g-1] ? i_value : r_cells[g-1]);
        end
        if (g == DEPTH - 1) begin : g_tail
            assign n_rem[g] = r_cells[g];
        end else begin : g_mid
            assign n_rem[g] = r_cells[g+1];
        end
    end

    // entry count after this beat
    always_comb begin
        n_count = r_count;
        if (i_cmd.remove) begin
            if (!empty) n_count = r_count - CW'(1);
        end else begin
            if (!full) n_count = r_count + CW'(1);
        end
    end

    // fill level wraps to the field width
    assign count_ext = 32'(n_count);

    // cell row, no reset: cells at or above the count are never read out
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i_cmd.remove) begin
                    if (!empty) r_cells[i] <= n_rem[i];
                end else begin
                    if (!full) r_cells[i] <= n_ins[i];
                end
            end
        end
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.go) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_fill_level <= count_ext[FILL_W-1:0];
            if (i_cmd.remove) begin
                r_result_value <= empty ? '0 : r_cells[0];
                r_status       <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_result_value <= '0;
                r_status       <= full ? ST_FULL : ST_OK;
            end
        end
    end

    assign o_result_value = r_result_value;
    assign o_status       = r_status;
    assign o_fill_level   = r_fill_level;

endmodule

`default_nettype wire

/* rtl/core/sorted_min_priority_queue.sv */
// sorted_min_priority_queue: top level, joins controller and cell datapath
// depends on smpq_pkg, smpq_if, smpq_ctrl, smpq_dp
//
//  port   dir  beat contents
//  i_in   in   action (0 insert, 1 remove), value (signed 32)
//  o_out  out  result_value (signed 32), status (2), fill_level (5)
//
// one beat per cycle while the result is not stalled: every cell compares with
// the new value and shifts in the same cycle that the beat is accepted.
// the result lands in an output register in the cycle after acceptance.
// reset clears the entry count and the result valid; cells are not cleared.
// a stalled result holds; a new beat is taken in the cycle the result drains.
`default_nettype none

module sorted_min_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    smpq_in_if.sink         i_in,
    smpq_out_if.source      o_out
);
    import smpq_pkg::*;

    t_cmd cmd;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    smpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_in.value),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status),
        .o_fill_level   (o_out.fill_level)
    );

endmodule

`default_nettype wire

/* test/tb_sorted_min_priority_queue.sv */
// tb_sorted_min_priority_queue: self-checking bench for the sorted min priority queue
// depends on smpq_pkg, smpq_if and the rtl/core sources of sorted_min_priority_queue
// a per-beat predictor checks every result beat; random idles, long stalls, drains
`default_nettype none

module tb_sorted_min_priority_queue;
    import smpq_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int          RAND_BEATS  = 950;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 4;

    typedef struct {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
        int                        gap;
        bit                        drain;
    } t_queued_beat;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
        logic [FILL_W-1:0]         fill;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    smpq_in_if  in_if ();
    smpq_out_if out_if ();

    sorted_min_priority_queue #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state and pending work
    logic signed [VALUE_W-1:0] sorted_entries[$];
    t_queue_result             predicted_results[$];
    t_queued_beat              pending_beats[$];

    int error_count = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    int beats_taken = 0;

    // driver-owned state
    t_queued_beat cur_beat;
    bit           have_beat = 0;
    int           gap_left  = 0;

    // receiver-owned state
    int rx_wait = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint actual, input longint wanted);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, actual, wanted);
        error_count++;
    endtask

    // idle draw: mostly 0..19, with stretches of no idling
    function automatic int pick_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // sorted insert / remove-min prediction for one accepted beat
    task automatic predict_queue_op(input logic action, input logic signed [VALUE_W-1:0] value);
        t_queue_result res;
        int            pos;
        res.value  = '0;
        res.status = ST_OK;
        if (action == ACT_INSERT) begin
            if (sorted_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos] < value)
                    pos++;
                sorted_entries.insert(pos, value);
            end
        end else begin
            if (sorted_entries.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.value = sorted_entries.pop_front();
            end
        end
        res.fill = FILL_W'(sorted_entries.size());
        predicted_results.push_back(res);
    endtask

    task automatic add_beat(input logic action, input logic signed [VALUE_W-1:0] value,
                            input bit drain);
        t_queued_beat b;
        b.action = action;
        b.value  = value;
        b.gap    = pick_idle(tx_calm);
        b.drain  = drain;
        pending_beats.push_back(b);
    endtask

    // random value in one of several shapes
    function automatic logic signed [VALUE_W-1:0] pick_value(input int shape);
        logic signed [VALUE_W-1:0] v;
        case (shape)
            0: begin
                v = $urandom;
            end
            1: begin
                v = $signed($urandom_range(0, 6)) - 3;
            end
            default: begin
                case ($urandom_range(0, 6))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sh8000_0001;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = -1;
                    5: v = 1;
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    // sender: presents queued beats, holds valid until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            have_beat   = 0;
            gap_left    = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_queue_op(cur_beat.action, cur_beat.value);
                have_beat = 0;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (!have_beat && pending_beats.size() > 0) begin
                    cur_beat  = pending_beats.pop_front();
                    have_beat = 1;
                    gap_left  = cur_beat.gap;
                end
                if (have_beat && gap_left == 0 &&
                    !(cur_beat.drain && predicted_results.size() > 0)) begin
                    in_if.valid  <= 1'b1;
                    in_if.action <= cur_beat.action;
                    in_if.value  <= cur_beat.value;
                end else begin
                    in_if.valid <= 1'b0;
                    if (have_beat && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // long receiver hold-off, started at two points of the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left   <= 0;
            beats_taken <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                beats_taken <= beats_taken + 1;
            if (in_if.valid && in_if.ready && (beats_taken == 299 || beats_taken == 699))
                hold_left <= HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // receiver: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (predicted_results.size() == 0) begin
                    report("unexpected result beat, value", out_if.result_value, 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (out_if.result_value !== want.value)
                        report("result_value", out_if.result_value, want.value);
                    if (out_if.status !== want.status)
                        report("status", out_if.status, want.status);
                    if (out_if.fill_level !== want.fill)
                        report("fill_level", out_if.fill_level, want.fill);
                end
                rx_wait = pick_idle(rx_calm);
            end
            out_if.ready <= (rx_wait == 0) && (hold_left == 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int made;
        int burst_len;
        int insert_pct;
        int shape;
        int next_drain;
        logic act;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.action = ACT_INSERT;
        in_if.value  = '0;
        out_if.ready = 1'b0;

        // directed: empty remove, extremes, equal values, fill to full, full insert
        add_beat(ACT_REMOVE, 32'shFFFF_FFFF, 0);
        add_beat(ACT_INSERT, 32'sh7FFF_FFFF, 0);
        add_beat(ACT_INSERT, 32'sh8000_0000, 0);
        add_beat(ACT_INSERT, 0, 0);
        add_beat(ACT_INSERT, -1, 0);
        add_beat(ACT_INSERT, 0, 0);
        add_beat(ACT_INSERT, 1, 0);
        add_beat(ACT_INSERT, 32'sh8000_0000, 0);
        add_beat(ACT_INSERT, 32'sh7FFF_FFFF, 0);
        add_beat(ACT_INSERT, 5, 0);
        add_beat(ACT_INSERT, -5, 0);
        add_beat(ACT_INSERT, 100, 0);
        add_beat(ACT_INSERT, -100, 0);
        add_beat(ACT_INSERT, 0, 0);
        add_beat(ACT_INSERT, 3, 0);
        add_beat(ACT_INSERT, -3, 0);
        add_beat(ACT_INSERT, 32'sh7FFF_FFFE, 0);
        add_beat(ACT_INSERT, 12345, 0);
        add_beat(ACT_REMOVE, 0, 0);
        add_beat(ACT_INSERT, 32'sh8000_0000, 0);
        add_beat(ACT_REMOVE, 32'sh5555_AAAA, 0);
        add_beat(ACT_REMOVE, 32'shAAAA_5555, 0);
        add_beat(ACT_INSERT, -2, 1);

        // random: bursts balanced or biased toward filling or draining the store
        made       = 0;
        next_drain = 150;
        while (made < RAND_BEATS) begin
            burst_len = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
                0: insert_pct = 20;
                1: insert_pct = 50;
                2: insert_pct = 80;
                default: insert_pct = 95;
            endcase
            shape = $urandom_range(0, 2);
            repeat (burst_len) begin
                act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
                add_beat(act, pick_value(shape), made == next_drain);
                if (made == next_drain)
                    next_drain += $urandom_range(100, 200);
                made++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait out every pending beat and prediction, then the output latency
        while (pending_beats.size() > 0 || have_beat || predicted_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
